// File: rtl/tgif_pkg.sv
// ----------------------------------------------------------------------------
// tgif_pkg: shared types for the gap filling row filter
// holds the payload structs, the sequencer states and the divider command
// ----------------------------------------------------------------------------
package tgif_pkg;

	typedef struct packed {
		logic               mode;
		logic        [31:0] time_stamp;
		logic signed [23:0] sample_a;
		logic signed [23:0] sample_b;
	} in_item_t;

	typedef struct packed {
		logic        [31:0] time_out;
		logic signed [23:0] value_a;
		logic signed [23:0] value_b;
		logic               is_synthetic;
		logic               gap_truncated;
		logic               last_of_run;
	} out_item_t;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WRITE,
		ST_CHECK,
		ST_RD_PREV,
		ST_RD_CUR,
		ST_GAP,
		ST_CNT_DIV,
		ST_CNT_WAIT,
		ST_LSUM,
		ST_RSUM,
		ST_MEAN_LA,
		ST_MEAN_LB,
		ST_MEAN_RA,
		ST_MEAN_RB,
		ST_MEAN_WAIT,
		ST_FILL_MUL,
		ST_FILL_DIVA,
		ST_FILL_WAITA,
		ST_FILL_DIVB,
		ST_FILL_WAITB,
		ST_FILL_OUT,
		ST_ORIG_OUT,
		ST_DONE
	} state_t;

	// divider request: unsigned magnitude over unsigned divisor, rounded half up
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] num;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic signed [64:0] quo;
	} div_rsp_t;

endpackage

// File: rtl/tgif_ram.sv
// ----------------------------------------------------------------------------
// tgif_ram: generic simple dual port ram with separate write and read addresses
// one write and one read per cycle, read data registered
// ----------------------------------------------------------------------------
module tgif_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/tgif_div.sv
// ----------------------------------------------------------------------------
// tgif_div: shared restoring divider
// one quotient bit per cycle, rounds the magnitude half up, applies the sign
// ----------------------------------------------------------------------------
module tgif_div
	import tgif_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic [33:0] trial;
	logic [64:0] num_r;

	// numerator with half the divisor added for round to nearest
	assign num_r = {1'b0, req.num} + {33'd0, req.den[32:1]};
	assign trial = {rem_q[32:0], quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= num_r[63:0];
			rem_q <= {33'd0, num_r[64]};
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (cnt_q != '0) begin
			if (!trial[33]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// the carry bit seeds the remainder, so it joins the first trial
	always_comb begin
		rsp.busy = (cnt_q != '0);
		rsp.quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	end

endmodule

// File: rtl/time_gap_interpolating_filler.sv
// ----------------------------------------------------------------------------
// time_gap_interpolating_filler: lookahead row filter with gap filling
// rows are held in a small history; on release, large time gaps are filled
// with rows interpolated between the left and right window means
// ----------------------------------------------------------------------------
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  input     | in_valid, in_ready, in_data      | in
//  result    | out_valid, out_ready, out_data   | out
//  config    | cfg_we, cfg_data (sample_period) | in
//
// a flush transfer releases one row when the history is not empty; a sample
// transfer is written to the history and releases one row once WINDOW_HALF
// rows are buffered, else it releases nothing
// a fill adds the reads of the left and right windows, a count division,
// four mean divisions (two if the right window is empty) and two divisions
// per synthetic row, all on the one shared divider, which sets the rate
// reset clears pointers, counters and the sequencer; history is left as is
// in_ready is high only in idle; an output stall holds the sequencer
// ----------------------------------------------------------------------------
module time_gap_interpolating_filler
	import tgif_pkg::*;
#(
	parameter int WINDOW_HALF = 8,
	parameter int MAX_FILL    = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [23:0] cfg_data
);

	localparam int DEPTH = 2 * WINDOW_HALF;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(DEPTH + 1);
	localparam int FW    = $clog2(MAX_FILL + 1);
	// fill offset width and interpolation product width
	localparam int OW    = FW + 24;
	localparam int PW    = OW + 26;

	state_t state_q, state_d;

	logic [23:0]   period_q;
	logic [AW-1:0] wptr_q;
	logic [BW-1:0] buffered_q;
	logic [31:0]   released_q;
	in_item_t      in_q;

	// history memories
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   t_rdata;
	logic [47:0]   s_rdata;

	tgif_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time_ram (
		.clk(clk), .we(ram_we), .waddr(wptr_q), .wdata(in_q.time_stamp),
		.raddr(ram_raddr), .rdata(t_rdata)
	);

	tgif_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_samp_ram (
		.clk(clk), .we(ram_we), .waddr(wptr_q),
		.wdata({in_q.sample_b, in_q.sample_a}),
		.raddr(ram_raddr), .rdata(s_rdata)
	);

	// shared divider
	div_req_t div_req;
	div_rsp_t div_rsp;

	tgif_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// working registers
	logic [31:0]        tprev_q, tcur_q;
	logic [47:0]        scur_q;
	logic [32:0]        gap_q;
	logic [23:0]        p_q;
	logic [FW-1:0]      cnt_q;
	logic [FW-1:0]      k_q;
	logic               trunc_q;
	logic [BW-1:0]      nl_q, nr_q;
	logic [BW-1:0]      idx_q;
	logic               rdv_q;
	logic signed [29:0] sla_q, slb_q, sra_q, srb_q;
	logic signed [23:0] la_q, lb_q, ra_q, rb_q;
	logic [1:0]         mean_sel_q;
	logic [OW-1:0]      off_q;
	logic signed [24:0] da, db;
	logic signed [PW-1:0] pa_q, pb_q;
	logic signed [23:0] va_q;
	logic [31:0]        tfill_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [AW-1:0]      back_idx;
	logic [BW-1:0]      back_n;
	logic signed [BW+1:0] back_sum;

	// slot back_n rows behind the write pointer, wrapped into the history
	always_comb begin
		back_sum = $signed((BW+2)'(wptr_q)) - $signed((BW+2)'(back_n))
			+ (BW+2)'(DEPTH);
		if (back_sum < 0) begin
			back_sum = back_sum + (BW+2)'(DEPTH);
		end else if (back_sum >= (BW+2)'(DEPTH)) begin
			back_sum = back_sum - (BW+2)'(DEPTH);
		end
	end

	assign back_idx = back_sum[AW-1:0];
	assign ram_raddr = back_idx;
	assign ram_we    = (state_q == ST_WRITE);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// read address is set in the state before the one that takes its registered data
	always_comb begin
		back_n = '0;
		case (state_q)
			ST_CHECK:             back_n = buffered_q + BW'(1);
			ST_RD_PREV, ST_RD_CUR: back_n = buffered_q;
			ST_LSUM:              back_n = buffered_q + idx_q;
			ST_RSUM:              back_n = idx_q;
			default:              back_n = buffered_q;
		endcase
	end

	logic signed [29:0] sa_ext, sb_ext;
	assign sa_ext = 30'(signed'(s_rdata[23:0]));
	assign sb_ext = 30'(signed'(s_rdata[47:24]));

	logic [32:0] p2;
	assign p2 = {8'd0, p_q, 1'b0};

	// mean differences for the interpolation
	assign da = 25'(ra_q) - 25'(la_q);
	assign db = 25'(rb_q) - 25'(lb_q);

	// next state
	always_comb begin
		state_d = state_q;
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.mode == MODE_SAMPLE) begin
						state_d = ST_WRITE;
					end else if (buffered_q != '0) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_CHECK: state_d = ST_RD_PREV;
			ST_RD_PREV: state_d = ST_RD_CUR;
			ST_RD_CUR: state_d = ST_GAP;
			ST_GAP: begin
				if (released_q != '0 && tcur_q > tprev_q
						&& gap_q > p2) begin
					state_d = ST_CNT_DIV;
				end else begin
					state_d = ST_ORIG_OUT;
				end
			end
			ST_CNT_DIV: begin
				// (2*gap + p) / (2*p), the divider adds the p
				div_req.start = 1'b1;
				div_req.num   = {30'd0, gap_q, 1'b0};
				div_req.den   = p2;
				state_d = ST_CNT_WAIT;
			end
			ST_CNT_WAIT: if (!div_rsp.busy) state_d = ST_LSUM;
			ST_LSUM: if (rdv_q && idx_q == nl_q + BW'(1)) state_d = ST_RSUM;
			ST_RSUM: begin
				if (nr_q == '0 || (rdv_q && idx_q == nr_q + BW'(1))) state_d = ST_MEAN_LA;
			end
			ST_MEAN_LA, ST_MEAN_LB, ST_MEAN_RA, ST_MEAN_RB: begin
				div_req.start = 1'b1;
				div_req.den   = {{(33-BW){1'b0}},
					(state_q == ST_MEAN_LA || state_q == ST_MEAN_LB) ? nl_q : nr_q};
				case (state_q)
					ST_MEAN_LA: begin
						div_req.neg = sla_q[29];
						div_req.num = 64'(sla_q[29] ? -sla_q : sla_q);
					end
					ST_MEAN_LB: begin
						div_req.neg = slb_q[29];
						div_req.num = 64'(slb_q[29] ? -slb_q : slb_q);
					end
					ST_MEAN_RA: begin
						div_req.neg = sra_q[29];
						div_req.num = 64'(sra_q[29] ? -sra_q : sra_q);
					end
					default: begin
						div_req.neg = srb_q[29];
						div_req.num = 64'(srb_q[29] ? -srb_q : srb_q);
					end
				endcase
				state_d = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (!div_rsp.busy) begin
					case (mean_sel_q)
						2'd0: state_d = ST_MEAN_LB;
						2'd1: state_d = (nr_q == '0) ? ST_FILL_MUL : ST_MEAN_RA;
						2'd2: state_d = ST_MEAN_RB;
						default: state_d = ST_FILL_MUL;
					endcase
				end
			end
			ST_FILL_MUL: state_d = ST_FILL_DIVA;
			ST_FILL_DIVA: begin
				div_req.start = 1'b1;
				div_req.neg   = pa_q[PW-1];
				div_req.num   = 64'(pa_q[PW-1] ? -pa_q : pa_q);
				div_req.den   = gap_q;
				state_d = ST_FILL_WAITA;
			end
			ST_FILL_WAITA: if (!div_rsp.busy) state_d = ST_FILL_DIVB;
			ST_FILL_DIVB: begin
				div_req.start = 1'b1;
				div_req.neg   = pb_q[PW-1];
				div_req.num   = 64'(pb_q[PW-1] ? -pb_q : pb_q);
				div_req.den   = gap_q;
				state_d = ST_FILL_WAITB;
			end
			ST_FILL_WAITB: if (!div_rsp.busy) state_d = ST_FILL_OUT;
			ST_FILL_OUT: begin
				if (out_free) begin
					state_d = (k_q == cnt_q) ? ST_ORIG_OUT : ST_FILL_MUL;
				end
			end
			ST_ORIG_OUT: if (out_free) state_d = ST_IDLE;
			ST_DONE: begin
				state_d = (buffered_q >= BW'(WINDOW_HALF)) ? ST_CHECK : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= 24'd1000;
			wptr_q      <= '0;
			buffered_q  <= '0;
			released_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) period_q <= cfg_data;
			if ((state_q == ST_FILL_OUT || state_q == ST_ORIG_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_WRITE) begin
				wptr_q     <= AW'((BW+1)'(wptr_q) + 1'b1 == (BW+1)'(DEPTH)
					? '0 : wptr_q + 1'b1);
				buffered_q <= buffered_q + BW'(1);
			end
			if (state_q == ST_ORIG_OUT && out_free) begin
				buffered_q <= buffered_q - BW'(1);
				if (released_q != '1) released_q <= released_q + 32'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) in_q <= in_data;
		case (state_q)
			ST_CHECK: begin
				p_q     <= (period_q == '0) ? 24'd1 : period_q;
				trunc_q <= 1'b0;
			end
			ST_RD_PREV: tprev_q <= t_rdata;
			ST_RD_CUR: begin
				tcur_q <= t_rdata;
				scur_q <= s_rdata;
				gap_q  <= {1'b0, t_rdata} - {1'b0, tprev_q};
			end
			ST_GAP: begin
				nl_q  <= (released_q < 32'(WINDOW_HALF)) ? BW'(released_q) : BW'(WINDOW_HALF);
				nr_q  <= buffered_q - BW'(1);
				idx_q <= BW'(1);
				rdv_q <= 1'b0;
				sla_q <= '0; slb_q <= '0; sra_q <= '0; srb_q <= '0;
				mean_sel_q <= 2'd0;
			end
			ST_CNT_WAIT: begin
				if (!div_rsp.busy) begin
					if (div_rsp.quo - 65'sd1 > 65'(MAX_FILL)) begin
						cnt_q   <= FW'(MAX_FILL);
						trunc_q <= 1'b1;
					end else begin
						cnt_q <= FW'(div_rsp.quo - 65'sd1);
					end
					k_q     <= FW'(1);
					off_q   <= OW'(p_q);
					tfill_q <= tprev_q + 32'(p_q);
				end
			end
			ST_LSUM, ST_RSUM: begin
				if (state_d != state_q) begin
					idx_q <= BW'(1);
					rdv_q <= 1'b0;
				end else begin
					rdv_q <= 1'b1;
					idx_q <= idx_q + BW'(1);
				end
				if (rdv_q) begin
					if (state_q == ST_LSUM) begin
						sla_q <= sla_q + sa_ext;
						slb_q <= slb_q + sb_ext;
					end else begin
						sra_q <= sra_q + sa_ext;
						srb_q <= srb_q + sb_ext;
					end
				end
			end
			ST_MEAN_WAIT: begin
				if (!div_rsp.busy) begin
					mean_sel_q <= mean_sel_q + 2'd1;
					case (mean_sel_q)
						2'd0: la_q <= 24'(div_rsp.quo);
						2'd1: begin
							lb_q <= 24'(div_rsp.quo);
							if (nr_q == '0) begin
								ra_q <= la_q;
								rb_q <= 24'(div_rsp.quo);
							end
						end
						2'd2: ra_q <= 24'(div_rsp.quo);
						default: rb_q <= 24'(div_rsp.quo);
					endcase
				end
			end
			ST_FILL_MUL: begin
				pa_q <= PW'(da) * PW'($signed({1'b0, off_q}));
				pb_q <= PW'(db) * PW'($signed({1'b0, off_q}));
			end
			ST_FILL_WAITA: if (!div_rsp.busy) va_q <= la_q + 24'(div_rsp.quo);
			ST_FILL_OUT: begin
				if (out_free) begin
					out_q.time_out      <= tfill_q;
					out_q.value_a       <= va_q;
					out_q.value_b       <= lb_q + 24'(div_rsp.quo);
					out_q.is_synthetic  <= 1'b1;
					out_q.gap_truncated <= trunc_q;
					out_q.last_of_run   <= 1'b0;
					k_q     <= k_q + FW'(1);
					off_q   <= off_q + OW'(p_q);
					tfill_q <= tfill_q + 32'(p_q);
				end
			end
			ST_ORIG_OUT: begin
				if (out_free) begin
					out_q.time_out      <= tcur_q;
					out_q.value_a       <= scur_q[23:0];
					out_q.value_b       <= scur_q[47:24];
					out_q.is_synthetic  <= 1'b0;
					out_q.gap_truncated <= trunc_q;
					out_q.last_of_run   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
